@@ design/sfd_pkg.sv @@
// shared types and constants for the stick frame deframer
package sfd_pkg;
  localparam logic [7:0]  HEADER_BYTE  = 8'h0F;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam int          MIN_LEN      = 22;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LONG   = 3'd1,
    ST_TOO_SHORT  = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_TOO_MANY   = 3'd4,
    ST_LEN_MISM   = 3'd5,
    ST_CRC_MISM   = 3'd6
  } status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > 31'h7F800000;
  endfunction

  function automatic logic [31:0] clamp_stick(input logic [31:0] v);
    if (is_nan(v)) return v;
    if (v[30:0] > 31'h3F800000) return v[31] ? 32'hBF800000 : 32'h3F800000;
    return v;
  endfunction

  function automatic logic [31:0] clamp_aux(input logic [31:0] v);
    if (is_nan(v)) return v;
    if (v[31]) return (v[30:0] != 31'd0) ? 32'd0 : v;
    if (v > 32'h3F800000) return 32'h3F800000;
    return v;
  endfunction
endpackage

@@ design/stick_frame_deframer_crc_unit.sv @@
// stick frame deframer: byte parser, crc check, channel store and result emitter
// result path: a good frame's first result passes busy, the read stage and the output
//   register; a failed frame's status result passes err_pend and the output register
// throughput: one byte per cycle; a good frame then emits 4+MAX_AUX results, one a cycle
//   while out_ready holds, during which the next frame's bytes are still taken (input stalls
//   only when a second frame ends before the previous frame's results are drained)
// reset: synchronous; clears the parser state, crc to all ones, the emitter to idle
module stick_frame_deframer_crc_unit #(
  parameter int MAX_AUX = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        end_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  channel,
  output logic [31:0] value_bits,
  output logic        last_result
);
  localparam int NUM_CH  = 4 + MAX_AUX;
  localparam int MAX_LEN = sfd_pkg::MIN_LEN + 4 * MAX_AUX;
  localparam int CHW     = 4;
  localparam int IW      = $clog2(2*NUM_CH);

  // two banks so a new frame can fill while the old one drains
  logic [31:0] mem [2*NUM_CH];

  logic [5:0]  byte_position;
  logic [7:0]  aux_count;
  logic        header_good;
  logic [31:0] word_shift;
  logic [31:0] crc_running;
  logic        wbank;

  // emitter state
  logic        busy;
  logic        rbank;
  logic [CHW-1:0] rch;
  logic [7:0]  raux;
  logic        err_pend;
  logic [2:0]  err_st;

  // read pipe stage
  logic        rd_v;
  logic [CHW-1:0] rd_ch;
  logic [7:0]  rd_aux;
  logic [31:0] rd_data;

  logic        ov;
  logic [2:0]  ost;
  logic [3:0]  och;
  logic [31:0] oval;
  logic        olast;

  logic        acc;
  logic [31:0] ws_next, crc_next;
  logic [5:0]  p;
  logic        wr_en;
  logic [CHW-1:0] wr_idx;
  logic [5:0]  len;
  logic [2:0]  st;
  logic        fire_rd;
  logic        stage_free;

  // mem index helper: bank*NUM_CH + ch
  logic [IW-1:0] widx, ridx;

  assign in_ready = !(busy || err_pend) || !end_of_frame;
  assign acc = in_valid && in_ready;
  assign p = byte_position;

  always_comb begin
    logic [5:0] q;
    q = '0;
    ws_next  = {word_shift[23:0], byte_value};
    crc_next = (p >= 6'd4) ? sfd_pkg::crc_byte(crc_running, word_shift[31:24]) : crc_running;
    wr_en  = 1'b0;
    wr_idx = '0;
    if (p >= 6'd1 && p <= 6'd16) begin
      q = p - 6'd1;
      wr_en  = (q[1:0] == 2'd3);
      wr_idx = CHW'(q[5:2]);
    end else if (p >= 6'd18 && 32'(p) <= MAX_LEN) begin
      q = p - 6'd18;
      wr_en  = (q[1:0] == 2'd3) && (32'(q[5:2]) < MAX_AUX);
      wr_idx = CHW'(q[5:2]) + CHW'(4);
    end
    len = (32'(p) < MAX_LEN + 1) ? p + 6'd1 : 6'(MAX_LEN + 1);
    if (32'(len) > MAX_LEN)                 st = sfd_pkg::ST_TOO_LONG;
    else if (32'(len) < sfd_pkg::MIN_LEN)   st = sfd_pkg::ST_TOO_SHORT;
    else if (!header_good)                  st = sfd_pkg::ST_BAD_HEADER;
    else if (32'(aux_count) > MAX_AUX)      st = sfd_pkg::ST_TOO_MANY;
    else if (32'(len) != sfd_pkg::MIN_LEN + 4 * 32'(aux_count)) st = sfd_pkg::ST_LEN_MISM;
    else if ((crc_next ^ sfd_pkg::CRC_ALL_ONES) != ws_next) st = sfd_pkg::ST_CRC_MISM;
    else                                    st = sfd_pkg::ST_OK;
  end

  assign widx = IW'(wbank ? NUM_CH : 0) + IW'(wr_idx);
  assign ridx = IW'(rbank ? NUM_CH : 0) + IW'(rch);

  always_ff @(posedge clk) begin
    if (acc && wr_en) mem[widx] <= ws_next;
  end

  assign stage_free = !ov || out_ready;
  // read is allowed when the read stage can move on
  assign fire_rd = busy && (!rd_v || stage_free);

  always_ff @(posedge clk) begin
    if (fire_rd) rd_data <= mem[ridx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      aux_count     <= '0;
      header_good   <= 1'b0;
      word_shift    <= '0;
      crc_running   <= sfd_pkg::CRC_ALL_ONES;
      wbank         <= 1'b0;
      busy          <= 1'b0;
      rbank         <= 1'b0;
      rch           <= '0;
      raux          <= '0;
      err_pend      <= 1'b0;
      err_st        <= '0;
      rd_v          <= 1'b0;
      ov            <= 1'b0;
    end else begin
      if (fire_rd) begin
        rd_ch  <= rch;
        rd_aux <= raux;
        if (32'(rch) == NUM_CH - 1) busy <= 1'b0;
        else rch <= rch + CHW'(1);
      end
      if (!rd_v || stage_free) rd_v <= fire_rd;

      if (stage_free) begin
        ov <= 1'b0;
        if (rd_v) begin
          ov    <= 1'b1;
          ost   <= sfd_pkg::ST_OK;
          och   <= rd_ch;
          olast <= (32'(rd_ch) == NUM_CH - 1);
          if (rd_ch < CHW'(4))           oval <= sfd_pkg::clamp_stick(rd_data);
          else if (8'(rd_ch - CHW'(4)) < rd_aux) oval <= sfd_pkg::clamp_aux(rd_data);
          else                            oval <= '0;
        end else if (err_pend) begin
          ov       <= 1'b1;
          ost      <= err_st;
          och      <= '0;
          oval     <= '0;
          olast    <= 1'b1;
          err_pend <= 1'b0;
        end
      end

      if (acc) begin
        if (end_of_frame) begin
          byte_position <= '0;
          aux_count     <= '0;
          header_good   <= 1'b0;
          word_shift    <= '0;
          crc_running   <= sfd_pkg::CRC_ALL_ONES;
          if (st == sfd_pkg::ST_OK) begin
            busy  <= 1'b1;
            rbank <= wbank;
            rch   <= '0;
            raux  <= aux_count;
            wbank <= !wbank;
          end else begin
            err_pend <= 1'b1;
            err_st   <= st;
          end
        end else begin
          byte_position <= len;
          word_shift    <= ws_next;
          crc_running   <= crc_next;
          if (p == 6'd0) header_good <= (byte_value == sfd_pkg::HEADER_BYTE);
          if (p == 6'd17) aux_count <= byte_value;
        end
      end
    end
  end

  assign out_valid   = ov;
  assign status      = ost;
  assign channel     = och;
  assign value_bits  = oval;
  assign last_result = olast;
endmodule
